/* hdl/ffd_pkg.sv */
// Shared types and constants of the fractional feedback delay unit.
// Used by ffd_wrap_reduce and fractional_feedback_delay_unit; depends on nothing.
package ffd_pkg;

    localparam int DELAY_W = 12;
    localparam int FRAC_W  = 15;
    localparam int GAIN_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_DELAY_WHOLE    = 3'd0;
    localparam cfg_idx_t REG_DELAY_FRACTION = 3'd1;
    localparam cfg_idx_t REG_FEEDBACK_GAIN  = 3'd2;
    localparam cfg_idx_t REG_FORWARD_GAIN   = 3'd3;
    localparam cfg_idx_t REG_MIX_GAIN       = 3'd4;

    localparam logic [DELAY_W-1:0] DELAY_WHOLE_RST    = 12'd1;
    localparam logic [FRAC_W-1:0]  DELAY_FRACTION_RST = 15'd0;
    localparam logic [GAIN_W-1:0]  FEEDBACK_GAIN_RST  = 16'd0;
    localparam logic [GAIN_W-1:0]  FORWARD_GAIN_RST   = 16'd16384;
    localparam logic [GAIN_W-1:0]  MIX_GAIN_RST       = 16'd16384;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_MUL4
    } seq_state_t;

endpackage

/* hdl/ffd_wrap_reduce.sv */
// Reduces the whole delay modulo the store depth by reciprocal multiplication.
// Depends on ffd_pkg.
module ffd_wrap_reduce #(
    parameter int BUF_DEPTH = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             load,
    input  logic [ffd_pkg::DELAY_W-1:0]      din,
    output logic                             busy,
    output logic [$clog2(BUF_DEPTH)-1:0]     dout
);
    import ffd_pkg::*;

    localparam int AW  = $clog2(BUF_DEPTH);
    localparam int SH  = DELAY_W + AW;
    localparam int PRW = 2 * DELAY_W + 2;
    localparam int BW  = DELAY_W + AW + 1;

    // The scaled reciprocal is rounded up, which keeps the quotient exact for every whole delay.
    localparam logic [63:0]    RECIP_FULL = ((64'd1 << SH) + 64'(BUF_DEPTH) - 64'd1)
                                            / 64'(BUF_DEPTH);
    localparam logic [PRW-1:0] RECIP      = RECIP_FULL[PRW-1:0];

    logic [DELAY_W-1:0] din_reg, din_next;
    logic [DELAY_W-1:0] quot_reg, quot_next;
    logic [AW-1:0]      rem_reg, rem_next;
    logic               busy_reg, busy_next;
    logic [PRW-1:0]     prod;
    logic [BW-1:0]      back;

    assign prod = PRW'(din) * RECIP;
    assign back = BW'(quot_reg) * BW'(BUF_DEPTH);

    always_comb
    begin
        din_next  = din_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        busy_next = 1'b0;
        if (load)
        begin
            din_next  = din;
            quot_next = DELAY_W'(prod >> SH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = AW'(din_reg - DELAY_W'(back));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            din_reg  <= '0;
            quot_reg <= '0;
            rem_reg  <= AW'(DELAY_WHOLE_RST);
            busy_reg <= 1'b0;
        end
        else
        begin
            din_reg  <= din_next;
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
            busy_reg <= busy_next;
        end
    end

    assign busy = busy_reg;
    assign dout = rem_reg;

endmodule

/* hdl/fractional_feedback_delay_unit.sv */
// Fractional delay line with linear interpolation and a feedback comb.
// Depends on ffd_pkg and ffd_wrap_reduce.
//
// One signed sample enters per beat and one saturated sample leaves for it. The sequencer
// takes a new sample only once the last has passed through: two reads of the delay memory
// one after the other, then four multiply stages, the store write falling in the third. A
// result waiting at the output does not stop the next sample being taken; the sequencer
// holds only at its last stage until the output register is free. After reset the memory
// is cleared one address at a time before the first sample is taken, and after each write
// of the whole delay the input waits while the delay is reduced modulo the memory depth.
module fractional_feedback_delay_unit #(
    parameter int BUF_DEPTH   = 4096,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // Fields from bit 0: sample_in.
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]        s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // Fields from bit 0: sample_out.
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]        m_axis_tdata,
    input  logic                                    cfg_write,
    input  ffd_pkg::cfg_idx_t                       cfg_index,
    input  logic [ffd_pkg::CFG_DATA_W-1:0]          cfg_data
);
    import ffd_pkg::*;

    localparam int S   = SAMPLE_BITS;
    localparam int AW  = $clog2(BUF_DEPTH);
    localparam int TDW = ((SAMPLE_BITS+7)/8)*8;
    localparam int PW  = S + 16;
    localparam int AccW = S + 17;

    localparam logic signed [AccW-1:0] RND15  = AccW'(16384);
    localparam logic signed [AccW-1:0] RND14  = AccW'(8192);
    localparam logic signed [AccW-1:0] SAT_HI = $signed({18'b0, {(S-1){1'b1}}});
    localparam logic signed [AccW-1:0] SAT_LO = $signed({{18{1'b1}}, {(S-1){1'b0}}});

    function automatic logic [S-1:0] sat_s(input logic signed [AccW-1:0] v);
        logic [S-1:0] r;
        if (v > SAT_HI)
        begin
            r = SAT_HI[S-1:0];
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO[S-1:0];
        end
        else
        begin
            r = v[S-1:0];
        end
        return r;
    endfunction

    // Configuration registers.
    logic [FRAC_W-1:0]         delay_fraction_reg;
    logic signed [GAIN_W-1:0]  feedback_gain_reg;
    logic signed [GAIN_W-1:0]  forward_gain_reg;
    logic signed [GAIN_W-1:0]  mix_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_fraction_reg <= DELAY_FRACTION_RST;
            feedback_gain_reg  <= FEEDBACK_GAIN_RST;
            forward_gain_reg   <= FORWARD_GAIN_RST;
            mix_gain_reg       <= MIX_GAIN_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DELAY_FRACTION: delay_fraction_reg <= cfg_data[FRAC_W-1:0];
                REG_FEEDBACK_GAIN:  feedback_gain_reg  <= $signed(cfg_data[GAIN_W-1:0]);
                REG_FORWARD_GAIN:   forward_gain_reg   <= $signed(cfg_data[GAIN_W-1:0]);
                REG_MIX_GAIN:       mix_gain_reg       <= $signed(cfg_data[GAIN_W-1:0]);
                default:            ;
            endcase
        end
    end

    // Whole delay reduced modulo the depth.
    logic          red_busy;
    logic [AW-1:0] d1;

    ffd_wrap_reduce #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_reduce (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (cfg_write && (cfg_index == REG_DELAY_WHOLE)),
        .din   (cfg_data[DELAY_W-1:0]),
        .busy  (red_busy),
        .dout  (d1)
    );

    // Sequencer state and pointers.
    seq_state_t    state_reg, state_next;
    logic [AW-1:0] w_reg, w_next;
    logic [AW-1:0] clr_idx_reg;
    logic          clr_last;

    // Read addresses behind the write position.
    logic [AW:0]   d0_ext, i1_diff, i0_diff;
    logic [AW-1:0] d0, i1, i0;

    assign d0_ext  = {1'b0, d1} + 1'b1;
    assign d0      = (d0_ext == (AW+1)'(BUF_DEPTH)) ? '0 : d0_ext[AW-1:0];
    assign i1_diff = {1'b0, w_reg} - {1'b0, d1};
    assign i0_diff = {1'b0, w_reg} - {1'b0, d0};
    assign i1      = i1_diff[AW] ? AW'(i1_diff + (AW+1)'(BUF_DEPTH)) : i1_diff[AW-1:0];
    assign i0      = i0_diff[AW] ? AW'(i0_diff + (AW+1)'(BUF_DEPTH)) : i0_diff[AW-1:0];
    assign w_next  = (w_reg == AW'(BUF_DEPTH - 1)) ? '0 : w_reg + 1'b1;
    assign clr_last = (clr_idx_reg == AW'(BUF_DEPTH - 1));

    // Sequencer outputs.
    logic tready;
    logic rd_en, rd_sel_i0;
    logic wr_en, wr_clear;
    logic out_load;
    logic accept;

    logic m_valid_reg;
    logic [S-1:0] m_data_reg;

    always_comb
    begin
        tready    = 1'b0;
        rd_en     = 1'b0;
        rd_sel_i0 = 1'b0;
        wr_en     = 1'b0;
        wr_clear  = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_clear = 1'b1;
            end
            ST_IDLE:
            begin
                tready = !red_busy;
                rd_en  = s_axis_tvalid && !red_busy;
            end
            ST_RD0:
            begin
                rd_en     = 1'b1;
                rd_sel_i0 = 1'b1;
            end
            ST_MUL3:
            begin
                wr_en = 1'b1;
            end
            ST_MUL4:
            begin
                out_load = !m_valid_reg || m_axis_tready;
            end
            default: ;
        endcase
    end

    assign accept = s_axis_tvalid && tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_last) state_next = ST_IDLE;
            ST_IDLE:  if (accept) state_next = ST_RD0;
            ST_RD0:   state_next = ST_MUL1;
            ST_MUL1:  state_next = ST_MUL2;
            ST_MUL2:  state_next = ST_MUL3;
            ST_MUL3:  state_next = ST_MUL4;
            ST_MUL4:  if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            w_reg       <= '0;
            clr_idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_MUL3)
            begin
                w_reg <= w_next;
            end
            if (state_reg == ST_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
        end
    end

    // Delay memory.
    logic [S-1:0]  store_mem [BUF_DEPTH];
    logic [S-1:0]  mem_rdata;
    logic [AW-1:0] mem_raddr, mem_waddr;
    logic [S-1:0]  mem_wdata;
    logic signed [S-1:0] x1;

    assign mem_raddr = rd_sel_i0 ? i0 : i1;
    assign mem_waddr = wr_clear ? clr_idx_reg : w_reg;
    assign mem_wdata = wr_clear ? '0 : x1;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            mem_rdata <= store_mem[mem_raddr];
        end
    end

    // Datapath.
    logic signed [S-1:0]    x_reg, y1_reg, est_reg, x1_reg;
    logic signed [AccW-1:0] prod1_reg;
    logic signed [PW-1:0]   fbp_reg, fwdp_reg;

    logic signed [S:0]      diff;
    logic signed [FRAC_W:0] frac_s;
    logic signed [AccW-1:0] prod1_next, rnd1, est_full, acc3, acc4;
    logic signed [S-1:0]    est_next;
    logic signed [PW-1:0]   fbp_next, fwdp_next, mixp;
    logic [S-1:0]           y_out;

    assign diff       = $signed({mem_rdata[S-1], mem_rdata}) - $signed({y1_reg[S-1], y1_reg});
    assign frac_s     = $signed({1'b0, delay_fraction_reg});
    assign prod1_next = diff * frac_s;

    assign rnd1      = (prod1_reg + RND15) >>> 15;
    assign est_full  = y1_reg + rnd1;
    assign est_next  = est_full[S-1:0];
    assign fbp_next  = est_next * feedback_gain_reg;

    assign acc3      = ($signed({{3{x_reg[S-1]}}, x_reg, 14'd0}) + fbp_reg + RND14) >>> 14;
    assign x1        = sat_s(acc3);
    assign fwdp_next = est_reg * forward_gain_reg;

    assign mixp      = x1_reg * mix_gain_reg;
    assign acc4      = (mixp + fwdp_reg + RND14) >>> 14;
    assign y_out     = sat_s(acc4);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg <= $signed(s_axis_tdata[S-1:0]);
        end
        if (state_reg == ST_RD0)
        begin
            y1_reg <= $signed(mem_rdata);
        end
        if (state_reg == ST_MUL1)
        begin
            prod1_reg <= prod1_next;
        end
        if (state_reg == ST_MUL2)
        begin
            est_reg <= est_next;
            fbp_reg <= fbp_next;
        end
        if (state_reg == ST_MUL3)
        begin
            x1_reg   <= x1;
            fwdp_reg <= fwdp_next;
        end
        if (out_load)
        begin
            m_data_reg <= y_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    assign s_axis_tready = tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = TDW'(m_data_reg);

endmodule
